[hdl/hrbp_pkg.sv]
// Package: shared types, constants and helpers for the HTTP request byte parser.
`default_nettype none
package hrbp_pkg;

   localparam int LENGTH_BITS_DEF = 32;
   localparam int CHUNK_BITS_DEF  = 32;

   // Parser phases
   localparam logic [2:0] PH_REQ   = 3'd0;
   localparam logic [2:0] PH_HDR   = 3'd1;
   localparam logic [2:0] PH_BODY  = 3'd2;
   localparam logic [2:0] PH_CHUNK = 3'd3;
   localparam logic [2:0] PH_DONE  = 3'd4;
   localparam logic [2:0] PH_ERR   = 3'd5;

   // Chunk sub-phases
   localparam logic [1:0] CK_SIZE  = 2'd0;
   localparam logic [1:0] CK_DATA  = 2'd1;
   localparam logic [1:0] CK_CRLF  = 2'd2;
   localparam logic [1:0] CK_TRAIL = 2'd3;

   // Header kinds
   localparam logic [1:0] KIND_OTHER = 2'd0;
   localparam logic [1:0] KIND_TE    = 2'd1;
   localparam logic [1:0] KIND_CL    = 2'd2;

   // Byte classes
   localparam logic [2:0] CLS_METHOD  = 3'd0;
   localparam logic [2:0] CLS_HVALUE  = 3'd4;
   localparam logic [2:0] CLS_HNAME   = 3'd3;
   localparam logic [2:0] CLS_BODY    = 3'd5;
   localparam logic [2:0] CLS_FRAMING = 3'd6;
   localparam logic [2:0] CLS_IGNORED = 3'd7;

   localparam logic [4:0] POS_DEAD = 5'd31;
   localparam logic [4:0] TE_LEN   = 5'd17;
   localparam logic [4:0] CL_LEN   = 5'd14;
   localparam logic [2:0] CK_LEN   = 3'd7;

   localparam logic [7:0] CHR_CR = 8'h0d;
   localparam logic [7:0] CHR_LF = 8'h0a;
   localparam logic [7:0] CHR_SP = 8'h20;
   localparam logic [7:0] CHR_COLON = 8'h3a;

   // One result item, queued between the parser and the output stage
   typedef struct packed {
      logic [2:0] byte_class;
      logic [7:0] out_byte;
      logic       message_done;
      logic       parse_error;
      logic       is_chunked;
      logic       last_of_run;
   } result_type;

   // Up to two results made by one input item
   typedef struct packed {
      logic       two;
      result_type first;
      result_type second;
   } pair_type;

   function automatic logic [7:0] to_lower(input logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;
   endfunction

   function automatic logic [7:0] te_char(input logic [4:0] p);
      logic [7:0] r;
      unique case (p)
         5'd0: r = "t"; 5'd1: r = "r"; 5'd2: r = "a"; 5'd3: r = "n"; 5'd4: r = "s";
         5'd5: r = "f"; 5'd6: r = "e"; 5'd7: r = "r"; 5'd8: r = "-"; 5'd9: r = "e";
         5'd10: r = "n"; 5'd11: r = "c"; 5'd12: r = "o"; 5'd13: r = "d";
         5'd14: r = "i"; 5'd15: r = "n"; 5'd16: r = "g";
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] cl_char(input logic [4:0] p);
      logic [7:0] r;
      unique case (p)
         5'd0: r = "c"; 5'd1: r = "o"; 5'd2: r = "n"; 5'd3: r = "t"; 5'd4: r = "e";
         5'd5: r = "n"; 5'd6: r = "t"; 5'd7: r = "-"; 5'd8: r = "l"; 5'd9: r = "e";
         5'd10: r = "n"; 5'd11: r = "g"; 5'd12: r = "t"; 5'd13: r = "h";
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] ck_char(input logic [2:0] p);
      logic [7:0] r;
      unique case (p)
         3'd0: r = "c"; 3'd1: r = "h"; 3'd2: r = "u"; 3'd3: r = "n";
         3'd4: r = "k"; 3'd5: r = "e"; 3'd6: r = "d";
         default: r = 8'h00;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

[hdl/http_request_byte_parser_unit.sv]
// Top level: HTTP request byte parser with stream ports.
`default_nettype none
// Labels each byte of an HTTP/1.1 request stream (request line, headers,
// fixed or chunked body). One byte is taken per cycle; each byte yields zero
// (a held CR), one or two result items, the latter when a held CR is released
// with the next byte. The front end works out all parser state at once;
// a four-entry queue feeds the result port, so the input stalls only when
// the result side falls behind. Results pass a front register, then the queue.
module http_request_byte_parser_unit #(
   parameter int LENGTH_BITS = hrbp_pkg::LENGTH_BITS_DEF,
   parameter int CHUNK_BITS  = hrbp_pkg::CHUNK_BITS_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,  // data_byte
   input  wire logic       req_tuser,  // start_new
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,  // out_byte
   output logic [5:0]      rsp_tuser,  // byte_class[2:0], message_done, parse_error, is_chunked
   output logic            rsp_tlast   // last_of_run
);

   logic                 pr_valid;
   logic                 pr_ready;
   hrbp_pkg::pair_type   pr_data;
   hrbp_pkg::result_type res;

   hrbp_front #(.LENGTH_BITS(LENGTH_BITS), .CHUNK_BITS(CHUNK_BITS)) u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready),
      .in_byte(req_tdata), .in_start(req_tuser),
      .pr_valid(pr_valid), .pr_ready(pr_ready), .pr_data(pr_data)
   );

   hrbp_back u_back (
      .clock(clock), .reset(reset),
      .pr_valid(pr_valid), .pr_ready(pr_ready), .pr_data(pr_data),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_data(res)
   );

   assign rsp_tdata = res.out_byte;
   assign rsp_tuser = {res.is_chunked, res.parse_error, res.message_done, res.byte_class};
   assign rsp_tlast = res.last_of_run;

endmodule
`default_nettype wire

[hdl/hrbp_front.sv]
// Front end: classifies each byte and updates the parser state, one item a cycle while the queue accepts results.
`default_nettype none
module hrbp_front #(
   parameter int LENGTH_BITS = hrbp_pkg::LENGTH_BITS_DEF,
   parameter int CHUNK_BITS  = hrbp_pkg::CHUNK_BITS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire logic [7:0]        in_byte,
   input  wire logic              in_start,
   output logic                   pr_valid,
   input  wire logic              pr_ready,
   output hrbp_pkg::pair_type     pr_data
);

   localparam int LB = LENGTH_BITS;
   localparam int CB = CHUNK_BITS;

   logic [2:0]    phase_ff, phase_in;
   logic          crp_ff, crp_in;
   logic [1:0]    sp_ff, sp_in;
   logic          ls_ff, ls_in;
   logic          colon_ff, colon_in;
   logic          vlead_ff, vlead_in;
   logic [4:0]    tep_ff, tep_in;
   logic [4:0]    clp_ff, clp_in;
   logic [1:0]    kind_ff, kind_in;
   logic [2:0]    ckm_ff, ckm_in;
   logic          ckf_ff, ckf_in;
   logic [LB-1:0] len_ff, len_in;
   logic [CB-1:0] rem_ff, rem_in;
   logic [1:0]    cph_ff, cph_in;
   logic          hex_ff, hex_in;
   logic [1:0]    tsk_ff, tsk_in;

   logic              step;
   hrbp_pkg::pair_type pair;

   // Decimal and hex accumulation with saturation
   logic [LB+3:0] dec_wide;
   logic [3:0]    dec_digit;
   logic [CB+3:0] hex_wide;
   logic [3:0]    hex_digit;
   logic          hex_ok;
   logic [7:0]    lb;

   assign in_ready = !pr_valid || pr_ready;
   assign step     = in_valid && in_ready;
   assign lb       = hrbp_pkg::to_lower(in_byte);
   assign dec_digit = 4'(in_byte - 8'h30);
   assign dec_wide = ({4'd0, len_ff} << 3) + ({4'd0, len_ff} << 1) + (LB+4)'(dec_digit);

   always_comb begin
      hex_ok = 1'b1;
      hex_digit = 4'd0;
      if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
         hex_digit = 4'(in_byte - 8'h30);
      end else if (lb >= 8'h61 && lb <= 8'h66) begin
         hex_digit = 4'(lb - 8'h57);
      end else begin
         hex_ok = 1'b0;
      end
   end

   assign hex_wide = ({4'd0, rem_ff} << 4) + (CB+4)'(hex_digit);

   // Work out the next state and the results of one byte
   always_comb begin
      logic       lmode;
      logic [7:0] b;
      logic       handled;
      logic       nres;
      hrbp_pkg::result_type r;
      logic [2:0] cls;
      logic       done;
      phase_in = phase_ff; crp_in = crp_ff; sp_in = sp_ff; ls_in = ls_ff;
      colon_in = colon_ff; vlead_in = vlead_ff; tep_in = tep_ff; clp_in = clp_ff;
      kind_in = kind_ff; ckm_in = ckm_ff; ckf_in = ckf_ff; len_in = len_ff;
      rem_in = rem_ff; cph_in = cph_ff; hex_in = hex_ff; tsk_in = tsk_ff;
      pair = '0;
      b = in_byte;
      handled = 1'b0;
      nres = 1'b0;
      r = '0;
      cls = hrbp_pkg::CLS_IGNORED;
      done = 1'b0;
      if (in_start) begin
         phase_in = hrbp_pkg::PH_REQ; crp_in = 1'b0; sp_in = 2'd0; ls_in = 1'b1;
         colon_in = 1'b0; vlead_in = 1'b0; tep_in = 5'd0; clp_in = 5'd0;
         kind_in = hrbp_pkg::KIND_OTHER; ckm_in = 3'd0; ckf_in = 1'b0;
         len_in = '0; rem_in = '0; cph_in = hrbp_pkg::CK_SIZE; hex_in = 1'b1;
         tsk_in = 2'd0;
      end
      lmode = phase_in == hrbp_pkg::PH_REQ || phase_in == hrbp_pkg::PH_HDR ||
              (phase_in == hrbp_pkg::PH_CHUNK &&
               (cph_in == hrbp_pkg::CK_SIZE || cph_in == hrbp_pkg::CK_TRAIL));
      // Two passes: a released CR, then the byte itself
      for (int k = 0; k < 2; k++) begin
         logic       emit;
         logic [7:0] cb;
         logic       content;
         emit = 1'b0;
         content = 1'b0;
         cb = b;
         if (!handled) begin
            if (k == 0) begin
               if (lmode && crp_in) begin
                  crp_in = 1'b0;
                  if (b == hrbp_pkg::CHR_LF) begin
                     // Line end: CR now, LF in second pass
                     r = '0;
                     r.byte_class = hrbp_pkg::CLS_FRAMING;
                     r.out_byte = hrbp_pkg::CHR_CR;
                     r.parse_error = phase_in == hrbp_pkg::PH_ERR;
                     r.is_chunked = ckf_in;
                     pair.first = r;
                     nres = 1'b1;
                     done = 1'b0;
                     if (phase_in == hrbp_pkg::PH_REQ) begin
                        if (sp_in < 2'd2) begin
                           phase_in = hrbp_pkg::PH_ERR;
                        end else begin
                           phase_in = hrbp_pkg::PH_HDR;
                           ls_in = 1'b1; colon_in = 1'b0; vlead_in = 1'b0; tep_in = 5'd0;
                           clp_in = 5'd0; kind_in = hrbp_pkg::KIND_OTHER; ckm_in = 3'd0;
                        end
                     end else if (phase_in == hrbp_pkg::PH_HDR) begin
                        if (ls_in) begin
                           if (ckf_in) begin
                              phase_in = hrbp_pkg::PH_CHUNK; cph_in = hrbp_pkg::CK_SIZE;
                              hex_in = 1'b1; rem_in = '0;
                           end else if (len_in == '0) begin
                              phase_in = hrbp_pkg::PH_DONE; done = 1'b1;
                           end else begin
                              phase_in = hrbp_pkg::PH_BODY;
                              rem_in = (CB > LB) ? CB'(len_in) :
                                 (len_in > LB'({CB{1'b1}}) ? '1 : CB'(len_in));
                           end
                        end else begin
                           ls_in = 1'b1; colon_in = 1'b0; vlead_in = 1'b0; tep_in = 5'd0;
                           clp_in = 5'd0; kind_in = hrbp_pkg::KIND_OTHER; ckm_in = 3'd0;
                        end
                     end else if (cph_in == hrbp_pkg::CK_SIZE) begin
                        hex_in = 1'b1;
                        if (rem_in == '0) begin
                           cph_in = hrbp_pkg::CK_TRAIL; ls_in = 1'b1;
                        end else begin
                           cph_in = hrbp_pkg::CK_DATA;
                        end
                     end else begin
                        if (ls_in) begin
                           phase_in = hrbp_pkg::PH_DONE; done = 1'b1;
                        end else begin
                           ls_in = 1'b1;
                        end
                     end
                     cls = hrbp_pkg::CLS_FRAMING;
                     emit = 1'b1;
                     handled = 1'b1;
                  end else begin
                     content = 1'b1;
                     cb = hrbp_pkg::CHR_CR;
                  end
               end
            end else begin
               if (lmode) begin
                  if (b == hrbp_pkg::CHR_CR) begin
                     crp_in = 1'b1;
                  end else begin
                     content = 1'b1;
                  end
               end else if (phase_in == hrbp_pkg::PH_BODY) begin
                  if (rem_in != '0) rem_in = rem_in - 1'b1;
                  if (rem_in == '0) begin
                     phase_in = hrbp_pkg::PH_DONE; done = 1'b1;
                  end
                  cls = hrbp_pkg::CLS_BODY; emit = 1'b1;
               end else if (phase_in == hrbp_pkg::PH_CHUNK &&
                            cph_in == hrbp_pkg::CK_DATA) begin
                  if (rem_in != '0) rem_in = rem_in - 1'b1;
                  if (rem_in == '0) begin
                     cph_in = hrbp_pkg::CK_CRLF; tsk_in = 2'd2;
                  end
                  cls = hrbp_pkg::CLS_BODY; emit = 1'b1;
               end else if (phase_in == hrbp_pkg::PH_CHUNK) begin
                  if (tsk_in != 2'd0) tsk_in = tsk_in - 2'd1;
                  if (tsk_in == 2'd0) begin
                     cph_in = hrbp_pkg::CK_SIZE; hex_in = 1'b1; rem_in = '0;
                  end
                  cls = hrbp_pkg::CLS_FRAMING; emit = 1'b1;
               end else begin
                  cls = hrbp_pkg::CLS_IGNORED; emit = 1'b1;
               end
            end
            // Content byte of a line-oriented part
            if (content) begin
               emit = 1'b1;
               if (phase_in == hrbp_pkg::PH_REQ) begin
                  if (cb == hrbp_pkg::CHR_SP && sp_in < 2'd2) begin
                     sp_in = sp_in + 2'd1; cls = hrbp_pkg::CLS_FRAMING;
                  end else begin
                     cls = {1'b0, sp_in};
                  end
               end else if (phase_in == hrbp_pkg::PH_HDR) begin
                  ls_in = 1'b0;
                  if (!colon_in) begin
                     if (cb == hrbp_pkg::CHR_COLON) begin
                        colon_in = 1'b1; vlead_in = 1'b1; ckm_in = 3'd0;
                        if (tep_in == hrbp_pkg::TE_LEN) begin
                           kind_in = hrbp_pkg::KIND_TE;
                        end else if (clp_in == hrbp_pkg::CL_LEN) begin
                           kind_in = hrbp_pkg::KIND_CL; len_in = '0;
                        end else begin
                           kind_in = hrbp_pkg::KIND_OTHER;
                        end
                        cls = hrbp_pkg::CLS_FRAMING;
                     end else begin
                        tep_in = (tep_in >= hrbp_pkg::TE_LEN ||
                                  hrbp_pkg::to_lower(cb) != hrbp_pkg::te_char(tep_in)) ?
                                 hrbp_pkg::POS_DEAD : tep_in + 5'd1;
                        clp_in = (clp_in >= hrbp_pkg::CL_LEN ||
                                  hrbp_pkg::to_lower(cb) != hrbp_pkg::cl_char(clp_in)) ?
                                 hrbp_pkg::POS_DEAD : clp_in + 5'd1;
                        cls = hrbp_pkg::CLS_HNAME;
                     end
                  end else if (vlead_in && cb == hrbp_pkg::CHR_SP) begin
                     cls = hrbp_pkg::CLS_IGNORED;
                  end else begin
                     vlead_in = 1'b0;
                     if (kind_in == hrbp_pkg::KIND_TE) begin
                        if (hrbp_pkg::to_lower(cb) == hrbp_pkg::ck_char(ckm_in)) begin
                           ckm_in = ckm_in + 3'd1;
                        end else begin
                           ckm_in = (hrbp_pkg::to_lower(cb) == 8'h63) ? 3'd1 : 3'd0;
                        end
                        if (ckm_in >= hrbp_pkg::CK_LEN) begin
                           ckf_in = 1'b1; ckm_in = 3'd0;
                        end
                     end else if (kind_in == hrbp_pkg::KIND_CL) begin
                        // Only the byte pass accumulates; a released CR is not a digit
                        if (cb >= 8'h30 && cb <= 8'h39) begin
                           len_in = (dec_wide[LB+3:LB] != 4'd0) ? '1 : dec_wide[LB-1:0];
                        end else begin
                           kind_in = hrbp_pkg::KIND_OTHER;
                        end
                     end
                     cls = hrbp_pkg::CLS_HVALUE;
                  end
               end else if (cph_in == hrbp_pkg::CK_SIZE) begin
                  if (hex_in) begin
                     if (cb == hrbp_pkg::CHR_CR || !hex_ok) begin
                        hex_in = 1'b0;
                     end else begin
                        rem_in = (hex_wide[CB+3:CB] != 4'd0) ? '1 : hex_wide[CB-1:0];
                     end
                  end
                  cls = hrbp_pkg::CLS_FRAMING;
               end else begin
                  ls_in = 1'b0;
                  cls = hrbp_pkg::CLS_FRAMING;
               end
            end
            if (emit) begin
               r = '0;
               r.byte_class = cls;
               r.out_byte = cb;
               r.message_done = done;
               r.parse_error = phase_in == hrbp_pkg::PH_ERR;
               r.is_chunked = ckf_in;
               if (nres) begin
                  pair.second = r;
                  pair.two = 1'b1;
               end else begin
                  pair.first = r;
                  nres = 1'b1;
               end
               done = 1'b0;
            end
         end
      end
      if (pair.two) begin
         pair.second.last_of_run = 1'b1;
      end else begin
         pair.first.last_of_run = 1'b1;
      end
      if (!nres) pair.first.last_of_run = 1'b0;
   end

   // Register the parser state and hold results for the queue; a CR held alone makes none
   always_ff @(posedge clock) begin
      if (reset) begin
         pr_valid <= 1'b0;
         phase_ff <= hrbp_pkg::PH_REQ; crp_ff <= 1'b0; sp_ff <= 2'd0; ls_ff <= 1'b1;
         colon_ff <= 1'b0; vlead_ff <= 1'b0; tep_ff <= 5'd0; clp_ff <= 5'd0;
         kind_ff <= hrbp_pkg::KIND_OTHER; ckm_ff <= 3'd0; ckf_ff <= 1'b0;
         len_ff <= '0; rem_ff <= '0; cph_ff <= hrbp_pkg::CK_SIZE; hex_ff <= 1'b1;
         tsk_ff <= 2'd0;
      end else begin
         if (step) begin
            pr_valid <= pair.first.last_of_run || pair.two;
            pr_data <= pair;
            phase_ff <= phase_in; crp_ff <= crp_in; sp_ff <= sp_in; ls_ff <= ls_in;
            colon_ff <= colon_in; vlead_ff <= vlead_in; tep_ff <= tep_in; clp_ff <= clp_in;
            kind_ff <= kind_in; ckm_ff <= ckm_in; ckf_ff <= ckf_in; len_ff <= len_in;
            rem_ff <= rem_in; cph_ff <= cph_in; hex_ff <= hex_in; tsk_ff <= tsk_in;
         end else if (pr_ready) begin
            pr_valid <= 1'b0;
         end
      end
   end

endmodule
`default_nettype wire

[hdl/hrbp_back.sv]
// Back end: queues result pairs and sends them out one item a cycle while the receiver is ready.
`default_nettype none
module hrbp_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               pr_valid,
   output logic                    pr_ready,
   input  wire hrbp_pkg::pair_type pr_data,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output hrbp_pkg::result_type    out_data
);

   localparam int DEPTH = 4;

   hrbp_pkg::result_type q_ff [DEPTH];
   logic [1:0] rd_ff, rd_in;
   logic [1:0] wr_ff, wr_in;
   logic [2:0] cnt_ff, cnt_in;
   logic       pop;
   logic [1:0] npush;

   assign pr_ready  = cnt_ff <= 3'd2;
   assign out_valid = cnt_ff != 3'd0;
   assign out_data  = q_ff[rd_ff];
   assign pop       = out_valid && out_ready;
   assign npush     = (pr_valid && pr_ready) ? (pr_data.two ? 2'd2 : 2'd1) : 2'd0;
   assign rd_in     = rd_ff + {1'b0, pop};
   assign wr_in     = wr_ff + npush;
   assign cnt_in    = cnt_ff + {1'b0, npush} - {2'b0, pop};

   // Advance pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff <= 2'd0; wr_ff <= 2'd0; cnt_ff <= 3'd0;
      end else begin
         rd_ff <= rd_in; wr_ff <= wr_in; cnt_ff <= cnt_in;
      end
   end

   // Write one or two entries
   always_ff @(posedge clock) begin
      if (npush != 2'd0) begin
         q_ff[wr_ff] <= pr_data.first;
      end
      if (npush == 2'd2) begin
         q_ff[wr_ff + 2'd1] <= pr_data.second;
      end
   end

endmodule
`default_nettype wire
